[rtl/tmbi_pkg.sv]
// ----------------------------------------------------------------------------
// tmbi_pkg
// Shared codes and types for the tape machine bracket interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmbi_pkg;

    // item function codes
    localparam logic [1:0] F_LOAD  = 2'd0;
    localparam logic [1:0] F_END   = 2'd1;
    localparam logic [1:0] F_STEP  = 2'd2;
    localparam logic [1:0] F_CLEAR = 2'd3;

    // result status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_BYTE     = 4'd1;
    localparam logic [3:0] ST_WAIT     = 4'd2;
    localparam logic [3:0] ST_HALT     = 4'd3;
    localparam logic [3:0] ST_UNEXP    = 4'd4;
    localparam logic [3:0] ST_UNCLOSED = 4'd5;
    localparam logic [3:0] ST_NEST     = 4'd6;
    localparam logic [3:0] ST_TOOLONG  = 4'd7;
    localparam logic [3:0] ST_PHASE    = 4'd8;

    // program characters
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [12:0] CNT_MAX = 13'd8191;

    // tape memory requests
    typedef struct packed {
        logic clr;
        logic rd;
        logic wr;
    } tape_ctl_t;

endpackage

`default_nettype wire

[rtl/tmbi_ram.sv]
// ----------------------------------------------------------------------------
// tmbi_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/tmbi_tape.sv]
// ----------------------------------------------------------------------------
// tmbi_tape
// Tape cell memory with a zeroing sweep after reset and on request.
// ----------------------------------------------------------------------------
`default_nettype none

module tmbi_tape
    import tmbi_pkg::*;
#(
    parameter int TAPE_DEPTH = 1024,
    parameter int TW         = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tape_ctl_t     ctl,
    input  wire logic [TW-1:0] rd_addr,
    input  wire logic [TW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    output logic      [7:0]    rd_data,
    output logic               clearing
);

    localparam logic [TW-1:0] LAST = TW'(TAPE_DEPTH - 1);

    logic [7:0]    mem [TAPE_DEPTH];
    logic          sweep_reg;
    logic          sweep_next;
    logic [TW-1:0] idx_reg;
    logic [TW-1:0] idx_next;

    // sweep control
    always_comb
    begin
        sweep_next = sweep_reg;
        idx_next   = idx_reg;
        if (ctl.clr)
        begin
            sweep_next = 1'b1;
            idx_next   = '0;
        end
        else if (sweep_reg)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == LAST)
            begin
                sweep_next = 1'b0;
                idx_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else
        begin
            sweep_reg <= sweep_next;
            idx_reg   <= idx_next;
        end
    end

    // cell array: sweep has the write port while it runs
    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            mem[idx_reg] <= 8'd0;
        end
        else if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign clearing = sweep_reg;

endmodule

`default_nettype wire

[rtl/tape_machine_bracket_interpreter_unit.sv]
// ----------------------------------------------------------------------------
// tape_machine_bracket_interpreter_unit
// Loads a tape-machine program, pairs brackets, then executes it step by step.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result word
// appears for one cycle with done high and cannot be held off. Loads, ends,
// clears and refused items give their word the cycle after acceptance; a
// closing bracket load then keeps busy while the partner table is written
// (stack read, then two partner writes on one port). A step first reads the
// program, partner and tape memories together, then the instruction completes
// and the cell is written back. Reset, a successful start and a clear each
// zero the tape, holding busy while the sweep runs.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_machine_bracket_interpreter_unit
    import tmbi_pkg::*;
#(
    parameter int PROG_DEPTH = 4096,
    parameter int TAPE_DEPTH = 1024,
    parameter int NEST_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  prog_byte,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_valid,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data,
    output logic             done,
    output logic [3:0]       status,
    output logic [7:0]       out_byte,
    output logic [12:0]      err_line,
    output logic [12:0]      err_column
);

    localparam int PW  = $clog2(PROG_DEPTH);
    localparam int LW  = PW + 1;
    localparam int NW  = $clog2(NEST_DEPTH);
    localparam int SW  = NW + 1;
    localparam int TW  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
    localparam int SZW = TW + 1;

    // phases
    localparam logic [1:0] PH_LOAD = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_HALT = 2'd2;
    localparam logic [1:0] PH_ERR  = 2'd3;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] pc_reg, pc_next;
    logic [TW-1:0] ptr_reg, ptr_next;
    logic [SW-1:0] level_reg, level_next;
    logic [12:0] line_reg, line_next;
    logic [12:0] col_reg, col_next;
    logic [3:0]  ecode_reg, ecode_next;
    logic [12:0] eline_reg, eline_next;
    logic [12:0] ecol_reg, ecol_next;
    logic [10:0] size_reg;
    logic [PW-1:0] ldpos_reg, ldpos_next;
    logic [PW-1:0] op_reg, op_next;
    logic [7:0]  inb_reg, inb_next;
    logic        inv_reg, inv_next;

    logic        done_reg, done_next;
    logic [3:0]  status_reg, status_next;
    logic [7:0]  ob_reg, ob_next;
    logic [12:0] rline_reg, rline_next;
    logic [12:0] rcol_reg, rcol_next;

    logic        accept;
    logic        clearing;
    logic        start_en;
    logic        store_en;
    logic        fail_en;
    logic [3:0]  fail_code;

    // memory ports
    logic          prog_we, prog_re;
    logic [7:0]    prog_rdata;
    logic          part_we, part_re;
    logic [PW-1:0] part_waddr, part_wdata, part_rdata;
    logic          stk_we, stk_re;
    logic [SW-1:0] lvl_m1;
    logic [PW-1:0] stk_rdata;
    tape_ctl_t     tape_ctl;
    logic [7:0]    tape_wdata, tape_rdata;

    // effective tape size and pointer moves
    logic [SZW-1:0] eff_sz, eff_m1, ptr_inc;
    logic [LW-1:0]  pc_sel;
    logic           adv;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE) || clearing;
    assign lvl_m1 = level_reg - 1'b1;

    always_comb
    begin
        if (size_reg == 11'd0)
        begin
            eff_sz = SZW'(1);
        end
        else if (32'(size_reg) > TAPE_DEPTH)
        begin
            eff_sz = SZW'(TAPE_DEPTH);
        end
        else
        begin
            eff_sz = SZW'(size_reg);
        end
    end

    assign eff_m1  = eff_sz - SZW'(1);
    assign ptr_inc = SZW'(ptr_reg) + SZW'(1);

    tmbi_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH), .AW(PW)) u_prog (
        .clk   (clk),
        .we    (prog_we),
        .waddr (len_reg[PW-1:0]),
        .wdata (prog_byte),
        .re    (prog_re),
        .raddr (pc_reg[PW-1:0]),
        .rdata (prog_rdata)
    );

    tmbi_ram #(.WIDTH(PW), .DEPTH(PROG_DEPTH), .AW(PW)) u_part (
        .clk   (clk),
        .we    (part_we),
        .waddr (part_waddr),
        .wdata (part_wdata),
        .re    (part_re),
        .raddr (pc_reg[PW-1:0]),
        .rdata (part_rdata)
    );

    tmbi_ram #(.WIDTH(PW), .DEPTH(NEST_DEPTH), .AW(NW)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (level_reg[NW-1:0]),
        .wdata (len_reg[PW-1:0]),
        .re    (stk_re),
        .raddr (lvl_m1[NW-1:0]),
        .rdata (stk_rdata)
    );

    tmbi_tape #(.TAPE_DEPTH(TAPE_DEPTH), .TW(TW)) u_tape (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tape_ctl),
        .rd_addr  (ptr_reg),
        .wr_addr  (ptr_reg),
        .wr_data  (tape_wdata),
        .rd_data  (tape_rdata),
        .clearing (clearing)
    );

    // sequencer and next state
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        len_next    = len_reg;
        pc_next     = pc_reg;
        ptr_next    = ptr_reg;
        level_next  = level_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        ecode_next  = ecode_reg;
        eline_next  = eline_reg;
        ecol_next   = ecol_reg;
        ldpos_next  = ldpos_reg;
        op_next     = op_reg;
        inb_next    = inb_reg;
        inv_next    = inv_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        ob_next     = 8'd0;
        rline_next  = 13'd0;
        rcol_next   = 13'd0;
        prog_we     = 1'b0;
        prog_re     = 1'b0;
        part_we     = 1'b0;
        part_re     = 1'b0;
        part_waddr  = ldpos_reg;
        part_wdata  = op_reg;
        stk_we      = 1'b0;
        stk_re      = 1'b0;
        tape_ctl    = '0;
        tape_wdata  = 8'd0;
        start_en    = 1'b0;
        store_en    = 1'b0;
        fail_en     = 1'b0;
        fail_code   = ST_OK;
        pc_sel      = pc_reg;
        adv         = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    if (func == F_CLEAR)
                    begin
                        len_next     = '0;
                        pc_next      = '0;
                        ptr_next     = '0;
                        level_next   = '0;
                        line_next    = 13'd1;
                        col_next     = 13'd1;
                        phase_next   = PH_LOAD;
                        ecode_next   = ST_OK;
                        eline_next   = 13'd0;
                        ecol_next    = 13'd0;
                        tape_ctl.clr = 1'b1;
                    end
                    else if (phase_reg == PH_ERR)
                    begin
                        status_next = ecode_reg;
                        rline_next  = eline_reg;
                        rcol_next   = ecol_reg;
                    end
                    else if (func == F_LOAD || func == F_END)
                    begin
                        if (phase_reg != PH_LOAD)
                        begin
                            status_next = ST_PHASE;
                        end
                        else if (func == F_END || prog_byte == CH_NUL)
                        begin
                            start_en = 1'b1;
                        end
                        else if (len_reg >= LW'(PROG_DEPTH))
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_TOOLONG;
                        end
                        else if (prog_byte == CH_OPEN)
                        begin
                            if (level_reg >= SW'(NEST_DEPTH))
                            begin
                                fail_en   = 1'b1;
                                fail_code = ST_NEST;
                            end
                            else
                            begin
                                stk_we     = 1'b1;
                                level_next = level_reg + 1'b1;
                                store_en   = 1'b1;
                            end
                        end
                        else if (prog_byte == CH_CLOSE)
                        begin
                            if (level_reg == '0)
                            begin
                                fail_en   = 1'b1;
                                fail_code = ST_UNEXP;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                level_next = lvl_m1;
                                ldpos_next = len_reg[PW-1:0];
                                state_next = S_POP;
                                store_en   = 1'b1;
                            end
                        end
                        else
                        begin
                            store_en = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_LOAD)
                    begin
                        status_next = ST_PHASE;
                    end
                    else if (phase_reg == PH_HALT)
                    begin
                        status_next = ST_HALT;
                    end
                    else if (pc_reg >= len_reg)
                    begin
                        phase_next  = PH_HALT;
                        status_next = ST_HALT;
                    end
                    else
                    begin
                        // fetch instruction, partner and cell together
                        prog_re     = 1'b1;
                        part_re     = 1'b1;
                        tape_ctl.rd = 1'b1;
                        inb_next    = in_byte;
                        inv_next    = in_valid;
                        done_next   = 1'b0;
                        state_next  = S_EXEC;
                    end
                end
            end

            S_POP:
            begin
                op_next    = stk_rdata;
                part_we    = 1'b1;
                part_waddr = stk_rdata;
                part_wdata = ldpos_reg;
                state_next = S_LINK;
            end

            S_LINK:
            begin
                part_we    = 1'b1;
                part_waddr = ldpos_reg;
                part_wdata = op_reg;
                state_next = S_IDLE;
            end

            S_EXEC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (prog_rdata)
                    CH_INC:
                    begin
                        tape_ctl.wr = 1'b1;
                        tape_wdata  = tape_rdata + 8'd1;
                    end
                    CH_DEC:
                    begin
                        tape_ctl.wr = 1'b1;
                        tape_wdata  = tape_rdata - 8'd1;
                    end
                    CH_OPEN:
                    begin
                        if (tape_rdata == 8'd0)
                        begin
                            pc_sel = LW'(part_rdata);
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (tape_rdata != 8'd0)
                        begin
                            pc_sel = LW'(part_rdata);
                        end
                    end
                    CH_LEFT:
                    begin
                        ptr_next = (ptr_reg == '0) ? eff_m1[TW-1:0] : ptr_reg - 1'b1;
                    end
                    CH_RIGHT:
                    begin
                        ptr_next = (ptr_inc >= eff_sz) ? '0 : ptr_inc[TW-1:0];
                    end
                    CH_OUT:
                    begin
                        status_next = ST_BYTE;
                        ob_next     = tape_rdata;
                    end
                    CH_IN:
                    begin
                        if (!inv_reg)
                        begin
                            status_next = ST_WAIT;
                            adv         = 1'b0;
                        end
                        else
                        begin
                            tape_ctl.wr = 1'b1;
                            tape_wdata  = inb_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (adv)
                begin
                    pc_next = pc_sel + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // store a loaded byte and move line/column
        if (store_en)
        begin
            prog_we  = 1'b1;
            len_next = len_reg + 1'b1;
            if (prog_byte == CH_NL)
            begin
                if (line_reg < CNT_MAX)
                begin
                    line_next = line_reg + 1'b1;
                end
                col_next = 13'd1;
            end
            else if (col_reg < CNT_MAX)
            begin
                col_next = col_reg + 1'b1;
            end
        end

        // end of program
        if (start_en)
        begin
            if (level_reg != '0)
            begin
                fail_en   = 1'b1;
                fail_code = ST_UNCLOSED;
            end
            else
            begin
                pc_next      = '0;
                ptr_next     = '0;
                phase_next   = PH_RUN;
                tape_ctl.clr = 1'b1;
            end
        end

        // sticky error
        if (fail_en)
        begin
            phase_next  = PH_ERR;
            ecode_next  = fail_code;
            eline_next  = line_reg;
            ecol_next   = col_reg;
            status_next = fail_code;
            rline_next  = line_reg;
            rcol_next   = col_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_LOAD;
            len_reg   <= '0;
            pc_reg    <= '0;
            ptr_reg   <= '0;
            level_reg <= '0;
            line_reg  <= 13'd1;
            col_reg   <= 13'd1;
            ecode_reg <= ST_OK;
            eline_reg <= 13'd0;
            ecol_reg  <= 13'd0;
            size_reg  <= 11'd1024;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pc_reg    <= pc_next;
            ptr_reg   <= ptr_next;
            level_reg <= level_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            ecode_reg <= ecode_next;
            eline_reg <= eline_next;
            ecol_reg  <= ecol_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ldpos_reg  <= ldpos_next;
        op_reg     <= op_next;
        inb_reg    <= inb_next;
        inv_reg    <= inv_next;
        status_reg <= status_next;
        ob_reg     <= ob_next;
        rline_reg  <= rline_next;
        rcol_reg   <= rcol_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_byte   = ob_reg;
    assign err_line   = rline_reg;
    assign err_column = rcol_reg;

    // checks
    a_pos_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status < ST_UNEXP || status > ST_TOOLONG)
        |-> err_line == 13'd0 && err_column == 13'd0)
        else $error("error position shown without an error status");

    a_sweep_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> state_reg == S_IDLE)
        else $error("tape sweep overlaps a sequencer operation");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= SW'(NEST_DEPTH))
        else $error("bracket stack level beyond its depth");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RUN |-> pc_reg <= len_reg)
        else $error("program counter beyond program end");

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tape machine bracket interpreter. A behavioural
// model tracks program store, bracket stack, tape and phase and predicts each
// result word. Directed tests cover every instruction and most error cases; a
// random phase loads well-formed programs and steps through them, mixed with
// noise items and broken programs.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import tmbi_pkg::*;

    localparam int PROG_MAX = 4096;
    localparam int TAPE_MAX = 1024;
    localparam int NEST_MAX = 256;
    localparam int WDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 190;

    typedef enum logic [1:0] {LOADING, RUNNING, HALTED, FAILED} run_phase_e;

    typedef struct {
        logic [3:0]  status;
        logic [7:0]  out_byte;
        logic [12:0] err_line;
        logic [12:0] err_column;
    } result_word_t;

    // DUT signals
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = F_LOAD;
    logic [7:0]  prog_byte = 8'd0;
    logic [7:0]  in_byte = 8'd0;
    logic        in_valid = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_data = 11'd0;
    logic        done;
    logic [3:0]  status;
    logic [7:0]  out_byte;
    logic [12:0] err_line;
    logic [12:0] err_column;

    // interpreter model state
    int          tape_len_reg;
    logic [7:0]  prog_mem [PROG_MAX];
    int          partner_of [PROG_MAX];
    int          open_pos [NEST_MAX];
    int          open_count;
    int          prog_len;
    int          line_no;
    int          col_no;
    int          pc;
    int          cell_ptr;
    logic [7:0]  tape [TAPE_MAX];
    run_phase_e  phase;
    logic [3:0]  stuck_code;
    int          stuck_line;
    int          stuck_col;

    result_word_t pending_words [$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          words_seen = 0;
    int          idle_cycles = 0;
    int          status_hits [16];

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tape_machine_bracket_interpreter_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .prog_byte  (prog_byte),
        .in_byte    (in_byte),
        .in_valid   (in_valid),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .out_byte   (out_byte),
        .err_line   (err_line),
        .err_column (err_column)
    );

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic void wipe_machine();
        for (int i = 0; i < TAPE_MAX; i++)
            tape[i] = 8'd0;
        open_count = 0;
        prog_len = 0;
        line_no = 1;
        col_no = 1;
        pc = 0;
        cell_ptr = 0;
        phase = LOADING;
        stuck_code = ST_OK;
        stuck_line = 0;
        stuck_col = 0;
    endfunction

    function automatic logic [3:0] raise_error(logic [3:0] code);
        phase = FAILED;
        stuck_code = code;
        stuck_line = line_no;
        stuck_col = col_no;
        return code;
    endfunction

    function automatic logic [3:0] begin_run();
        if (open_count != 0)
            return raise_error(ST_UNCLOSED);
        for (int i = 0; i < TAPE_MAX; i++)
            tape[i] = 8'd0;
        pc = 0;
        cell_ptr = 0;
        phase = RUNNING;
        return ST_OK;
    endfunction

    function automatic logic [3:0] store_char(logic [7:0] c);
        int pos;
        int opener;
        pos = prog_len;
        if (c == CH_NUL)
            return begin_run();
        if (pos >= PROG_MAX)
            return raise_error(ST_TOOLONG);
        if (c == CH_OPEN)
        begin
            if (open_count >= NEST_MAX)
                return raise_error(ST_NEST);
            open_pos[open_count] = pos;
            open_count++;
        end
        else if (c == CH_CLOSE)
        begin
            if (open_count == 0)
                return raise_error(ST_UNEXP);
            open_count--;
            opener = open_pos[open_count];
            partner_of[opener] = pos;
            partner_of[pos] = opener;
        end
        prog_mem[pos] = c;
        prog_len = pos + 1;
        if (c == CH_NL)
        begin
            if (line_no < CNT_MAX)
                line_no++;
            col_no = 1;
        end
        else if (col_no < CNT_MAX)
            col_no++;
        return ST_OK;
    endfunction

    function automatic logic [3:0] run_instruction(logic [7:0] ib, logic iv,
                                                   ref logic [7:0] ob);
        int p;
        int sz;
        int npc;
        logic [3:0] st;
        p = cell_ptr % TAPE_MAX;
        sz = (tape_len_reg == 0) ? 1 : (tape_len_reg > TAPE_MAX) ? TAPE_MAX : tape_len_reg;
        npc = pc;
        st = ST_OK;
        if (pc >= prog_len)
        begin
            phase = HALTED;
            return ST_HALT;
        end
        case (prog_mem[pc])
            CH_INC:   tape[p] = tape[p] + 8'd1;
            CH_DEC:   tape[p] = tape[p] - 8'd1;
            CH_OPEN:  if (tape[p] == 8'd0) npc = partner_of[pc];
            CH_CLOSE: if (tape[p] != 8'd0) npc = partner_of[pc];
            CH_LEFT:  cell_ptr = (p == 0) ? sz - 1 : p - 1;
            CH_RIGHT: cell_ptr = (p + 1 >= sz) ? 0 : p + 1;
            CH_OUT:
            begin
                st = ST_BYTE;
                ob = tape[p];
            end
            CH_IN:
            begin
                if (!iv)
                    return ST_WAIT;
                tape[p] = ib;
            end
            default: ;
        endcase
        pc = npc + 1;
        return st;
    endfunction

    function automatic result_word_t predict_word(logic [1:0] f, logic [7:0] pb,
                                                  logic [7:0] ib, logic iv);
        result_word_t w;
        logic [7:0] ob;
        logic [3:0] st;
        ob = 8'd0;
        if (f == F_CLEAR)
        begin
            wipe_machine();
            st = ST_OK;
        end
        else if (phase == FAILED)
            st = stuck_code;
        else if (f == F_LOAD)
            st = (phase == LOADING) ? store_char(pb) : ST_PHASE;
        else if (f == F_END)
            st = (phase == LOADING) ? begin_run() : ST_PHASE;
        else if (phase == LOADING)
            st = ST_PHASE;
        else if (phase == HALTED)
            st = ST_HALT;
        else
            st = run_instruction(ib, iv, ob);
        w.status = st;
        w.out_byte = ob;
        if (st >= ST_UNEXP && st <= ST_TOOLONG)
        begin
            w.err_line = 13'(stuck_line);
            w.err_column = 13'(stuck_col);
        end
        else
        begin
            w.err_line = 13'd0;
            w.err_column = 13'd0;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_word_t exp_w;
        if (rst_n && done)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                $error("result word with nothing pending, status %0d", status);
                mismatches++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                status_hits[exp_w.status]++;
                if (status !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, status);
                    mismatches++;
                end
                if (out_byte !== exp_w.out_byte)
                begin
                    $error("out_byte: expected %0d, got %0d", exp_w.out_byte, out_byte);
                    mismatches++;
                end
                if (err_line !== exp_w.err_line)
                begin
                    $error("err_line: expected %0d, got %0d", exp_w.err_line, err_line);
                    mismatches++;
                end
                if (err_column !== exp_w.err_column)
                begin
                    $error("err_column: expected %0d, got %0d",
                           exp_w.err_column, err_column);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on accepted words
    always @(posedge clk)
    begin
        if (start && !busy)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", WDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------
    task automatic send_word(logic [1:0] f, logic [7:0] pb, logic [7:0] ib, logic iv);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        prog_byte <= pb;
        in_byte <= ib;
        in_valid <= iv;
        do
            @(posedge clk);
        while (busy);
        pending_words.push_back(predict_word(f, pb, ib, iv));
        words_sent++;
    endtask

    task automatic load_char(logic [7:0] c);
        send_word(F_LOAD, c, 8'($urandom), 1'($urandom));
    endtask

    task automatic step_once(logic iv);
        send_word(F_STEP, 8'($urandom), 8'($urandom), iv);
    endtask

    task automatic clear_machine();
        send_word(F_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // wait until all words are back and the block is free
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tape_size(logic [10:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tape_len_reg = v;
    endtask

    task automatic load_string(string s);
        for (int i = 0; i < s.len(); i++)
            load_char(s[i]);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_instructions();
        write_tape_size(11'd3);
        // wraps left, reads with and without input, loops, output
        load_string("+<.,.>-.a\n[-]");
        load_char(CH_OPEN);
        load_char(CH_CLOSE);
        load_char(CH_NUL);
        step_once(1'b1);
        step_once(1'b1);
        step_once(1'b1);
        step_once(1'b0);
        step_once(1'b1);
        repeat (12) step_once(1'b1);
        step_once(1'b0);
    endtask

    task automatic test_wrong_phase();
        load_char(CH_INC);
        send_word(F_END, 8'd0, 8'd0, 1'b0);
        clear_machine();
        step_once(1'b1);
        load_string("+++.");
        send_word(F_END, 8'hFF, 8'hFF, 1'b1);
        repeat (6) step_once(1'b0);
    endtask

    task automatic test_bracket_errors();
        clear_machine();
        load_string("+\n+]");
        load_char(CH_INC);
        step_once(1'b1);
        clear_machine();
        load_string("[[\n]");
        send_word(F_END, 8'd0, 8'd0, 1'b0);
        load_char(CH_INC);
        clear_machine();
    endtask

    task automatic test_nesting_overflow();
        for (int i = 0; i <= NEST_MAX; i++)
            load_char(CH_OPEN);
        load_char(CH_CLOSE);
        clear_machine();
    endtask

    task automatic test_tape_sizes();
        write_tape_size(11'd0);
        load_string("+>+<.>.");
        load_char(CH_NUL);
        repeat (8) step_once(1'b1);
        write_tape_size(11'd1024);
        clear_machine();
        load_string(">+.<<.");
        load_char(CH_NUL);
        repeat (7) step_once(1'b1);
    endtask

    task automatic test_random_programs();
        int first;
        int depth;
        int len;
        int pick;
        logic [7:0] c;
        first = words_sent;
        while (words_sent - first < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // noise word
                send_word(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                continue;
            end
            if (pick == 1)
            begin
                case ($urandom_range(0, 3))
                    0: write_tape_size(11'd1);
                    1: write_tape_size(11'd2047);
                    default: write_tape_size(11'($urandom_range(1, 40)));
                endcase
            end
            clear_machine();
            depth = 0;
            len = $urandom_range(3, 24);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 11))
                    0, 1: c = CH_INC;
                    2:    c = CH_DEC;
                    3:    c = CH_LEFT;
                    4:    c = CH_RIGHT;
                    5:    c = CH_OUT;
                    6:    c = CH_IN;
                    7:    c = CH_NL;
                    8:    c = 8'($urandom_range(1, 255));
                    9:    c = CH_OPEN;
                    default: c = (depth > 0 || $urandom_range(0, 9) == 0) ? CH_CLOSE : CH_INC;
                endcase
                if (c == CH_OPEN)
                    depth++;
                else if (c == CH_CLOSE && depth > 0)
                    depth--;
                load_char(c);
            end
            // close what is open, bar the odd broken program
            if ($urandom_range(0, 7) != 0)
                while (depth > 0)
                begin
                    load_char(CH_CLOSE);
                    depth--;
                end
            if ($urandom_range(0, 1))
                load_char(CH_NUL);
            else
                send_word(F_END, 8'($urandom), 8'($urandom), 1'($urandom));
            repeat ($urandom_range(4, 40))
                step_once($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                drain();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        tape_len_reg = TAPE_MAX;
        wipe_machine();
        for (int i = 0; i < 16; i++)
            status_hits[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        test_instructions();
        test_wrong_phase();
        test_bracket_errors();
        test_nesting_overflow();
        test_tape_sizes();
        test_random_programs();

        drain();
        repeat (10) @(posedge clk);
        $display("words sent %0d, results checked %0d", words_sent, words_seen);
        $display("status hits: ok %0d byte %0d wait %0d halt %0d err %0d phase %0d",
                 status_hits[ST_OK], status_hits[ST_BYTE], status_hits[ST_WAIT],
                 status_hits[ST_HALT],
                 status_hits[ST_UNEXP] + status_hits[ST_UNCLOSED] +
                 status_hits[ST_NEST] + status_hits[ST_TOOLONG],
                 status_hits[ST_PHASE]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/tmbi_pkg.sv
rtl/tmbi_ram.sv
rtl/tmbi_tape.sv
rtl/tape_machine_bracket_interpreter_unit.sv
dv/testbench.sv
